### rtl/core/max_heap_rekey_sift_down_top_defines.svh
// Assertion macros shared by the heap rekey block.
`ifndef MAX_HEAP_REKEY_SIFT_DOWN_TOP_DEFINES_SVH
`define MAX_HEAP_REKEY_SIFT_DOWN_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MHR_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MHR_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/mhr_pkg.sv
// Package: widths, types and codes of the heap rekey block.
`timescale 1ns / 1ps
`default_nettype none
package mhr_pkg;
	localparam int HEAP_CAPACITY = 64;
	localparam int ID_COUNT      = 256;
	localparam int KEY_BITS      = 32;
	localparam int MOVE_DEPTH    = 6;

	localparam int ADDR_W  = $clog2(HEAP_CAPACITY);
	localparam int COUNT_W = $clog2(HEAP_CAPACITY + 1);
	localparam int KIDX_W  = ADDR_W + 2;
	localparam int ID_W    = $clog2(ID_COUNT);
	localparam int MOVE_W  = $clog2(MOVE_DEPTH + 1);

	typedef logic [ADDR_W-1:0]          slot_t;
	typedef logic [COUNT_W-1:0]         count_t;
	typedef logic [KIDX_W-1:0]          kidx_t;
	typedef logic [ID_W-1:0]            id_t;
	typedef logic signed [KEY_BITS-1:0] key_t;
	typedef logic [MOVE_W-1:0]          move_t;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_REKEY = 1'b1;

	typedef struct packed {
		key_t key;
		id_t  id;
	} entry_t;

	typedef enum logic [1:0] {
		OUT_MOVED,
		OUT_LAST_STAY,
		OUT_LAST_MOVED,
		OUT_ERROR
	} out_kind_t;

	typedef struct packed {
		logic      wr_in;
		logic      load_op;
		logic      rd_slot;
		logic      rd_kids;
		logic      load_mov;
		logic      step;
		logic      place;
		logic      out_load;
		out_kind_t out_kind;
		move_t     buf_idx;
	} mhr_cmd_t;

	typedef struct packed {
		logic slot_err;
		logic has_move;
	} mhr_sts_t;
endpackage
`default_nettype wire

### rtl/core/mhr_ifs.sv
// Interfaces: input item channel and result channel.
`timescale 1ns / 1ps
`default_nettype none
interface mhr_in_if
	import mhr_pkg::*;
	();
	logic  valid;
	logic  ready;
	logic  opcode;
	slot_t slot_index;
	key_t  key;
	id_t   entry_id;

	modport source (output valid, opcode, slot_index, key, entry_id, input ready);
	modport sink   (input valid, opcode, slot_index, key, entry_id, output ready);
endinterface

interface mhr_out_if
	import mhr_pkg::*;
	();
	logic valid;
	logic ready;
	id_t  touched_id;
	logic last_of_run;
	logic index_error;
	key_t root_key;

	modport source (output valid, touched_id, last_of_run, index_error, root_key, input ready);
	modport sink   (input valid, touched_id, last_of_run, index_error, root_key, output ready);
endinterface
`default_nettype wire

### rtl/core/max_heap_rekey_sift_down_top.sv
// Top level: binary max-heap rekey engine with sift-down.
//
// Input channel in_ch carries one item per transfer: opcode, slot_index, key, entry_id.
// A write item (opcode 0) stores key and id at the slot and gives no result.
// A rekey item (opcode 1) replaces the key at the slot and sifts it down the heap;
// results leave on out_ch: the ids that moved up, deepest first, then the id now at
// the slot with last_of_run set and root_key. A slot at or beyond heap_count gives a
// single result with index_error set.
// The user must write heap_count through cfg_we / cfg_wdata only while the block is idle;
// the block itself does not enforce this. A rekey reads the slot, then for each level reads
// both children and then compares and swaps, then places the entry, reads the root and
// loads the first result; then one result per cycle while out_ch is ready. At most six
// ids move, so up to seven levels are compared; from a rekey's input transfer until its
// last result is loaded in_ch is not ready, while a write leaves it ready.
// Only one item is in work at a time; in_ch is ready while the engine is idle, also
// when the final result still waits in the output register.
// A stalled receiver holds the output register and the sequencer until it drains.
// Reset clears heap_count and the control state; heap contents stay undefined until
// written.
`timescale 1ns / 1ps
`default_nettype none
module max_heap_rekey_sift_down_top
	import mhr_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   cfg_we,
	input  wire count_t cfg_wdata,
	mhr_in_if.sink      in_ch,
	mhr_out_if.source   out_ch
);
	mhr_cmd_t cmd;
	mhr_sts_t sts;

	mhr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_opcode (in_ch.opcode),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mhr_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_slot_index (in_ch.slot_index),
		.in_key        (in_ch.key),
		.in_entry_id   (in_ch.entry_id),
		.cmd           (cmd),
		.sts           (sts),
		.touched_id    (out_ch.touched_id),
		.last_of_run   (out_ch.last_of_run),
		.index_error   (out_ch.index_error),
		.root_key      (out_ch.root_key)
	);
endmodule
`default_nettype wire

### rtl/core/mhr_datapath.sv
// Datapath: heap memory, sift registers, moved-id buffer and result register.
`timescale 1ns / 1ps
`default_nettype none
module mhr_datapath
	import mhr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cfg_we,
	input  wire count_t   cfg_wdata,
	input  wire slot_t    in_slot_index,
	input  wire key_t     in_key,
	input  wire id_t      in_entry_id,
	input  wire mhr_cmd_t cmd,
	output mhr_sts_t      sts,
	output id_t           touched_id,
	output logic          last_of_run,
	output logic          index_error,
	output key_t          root_key
);
	entry_t mem [HEAP_CAPACITY];
	entry_t rdata_a_q, rdata_b_q;
	slot_t  raddr_a, raddr_b, waddr;
	entry_t wdata;
	logic   we;

	count_t heap_count_q;
	count_t used_n;
	slot_t  slot_q, pos_q;
	key_t   key_q;
	id_t    mov_id_q;
	id_t    moved_q [MOVE_DEPTH];

	kidx_t  left_idx, right_idx;
	logic   left_ok, right_ok, left_win, right_win;
	key_t   best_key;
	entry_t big_entry;
	kidx_t  big_idx;

	id_t    touched_q;
	logic   last_q, err_q;
	key_t   root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_count_q <= '0;
		end else if (cfg_we) begin
			heap_count_q <= cfg_wdata;
		end
	end

	assign used_n = (heap_count_q > count_t'(HEAP_CAPACITY)) ? count_t'(HEAP_CAPACITY)
		: heap_count_q;
	assign sts.slot_err = (count_t'(in_slot_index) >= used_n);

	assign left_idx  = {1'b0, pos_q, 1'b1};
	assign right_idx = left_idx + kidx_t'(1);
	assign left_ok   = left_idx < kidx_t'(used_n);
	assign right_ok  = right_idx < kidx_t'(used_n);
	assign left_win  = left_ok && ($signed(rdata_a_q.key) > $signed(key_q));
	assign best_key  = left_win ? rdata_a_q.key : key_q;
	assign right_win = right_ok && ($signed(rdata_b_q.key) > $signed(best_key));
	assign big_entry = right_win ? rdata_b_q : rdata_a_q;
	assign big_idx   = right_win ? right_idx : left_idx;
	assign sts.has_move = left_win || right_win;

	always_comb begin
		raddr_a = '0;
		raddr_b = '0;
		if (cmd.rd_slot) begin
			raddr_a = slot_q;
		end else if (cmd.rd_kids) begin
			raddr_a = left_idx[ADDR_W-1:0];
			raddr_b = right_idx[ADDR_W-1:0];
		end
	end

	always_comb begin
		we    = cmd.wr_in || cmd.step || cmd.place;
		waddr = pos_q;
		wdata = '{key: key_q, id: mov_id_q};
		if (cmd.wr_in) begin
			waddr = in_slot_index;
			wdata = '{key: in_key, id: in_entry_id};
		end else if (cmd.step) begin
			wdata = big_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a_q <= mem[raddr_a];
		rdata_b_q <= mem[raddr_b];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_op) begin
			slot_q <= in_slot_index;
			pos_q  <= in_slot_index;
			key_q  <= in_key;
		end else if (cmd.step) begin
			pos_q <= big_idx[ADDR_W-1:0];
		end
		if (cmd.load_mov) begin
			mov_id_q <= rdata_a_q.id;
		end
		if (cmd.step) begin
			moved_q[cmd.buf_idx] <= big_entry.id;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.out_kind)
				OUT_MOVED: begin
					touched_q <= moved_q[cmd.buf_idx];
					last_q    <= 1'b0;
					err_q     <= 1'b0;
					root_q    <= '0;
				end
				OUT_LAST_STAY: begin
					touched_q <= mov_id_q;
					last_q    <= 1'b1;
					err_q     <= 1'b0;
					root_q    <= rdata_a_q.key;
				end
				OUT_LAST_MOVED: begin
					touched_q <= moved_q[0];
					last_q    <= 1'b1;
					err_q     <= 1'b0;
					root_q    <= rdata_a_q.key;
				end
				default: begin
					touched_q <= '0;
					last_q    <= 1'b1;
					err_q     <= 1'b1;
					root_q    <= '0;
				end
			endcase
		end
	end

	assign touched_id  = touched_q;
	assign last_of_run = last_q;
	assign index_error = err_q;
	assign root_key    = root_q;
endmodule
`default_nettype wire

### rtl/core/mhr_ctrl.sv
// Controller: sequencing of writes, sift-down steps and result transfers.
`timescale 1ns / 1ps
`default_nettype none
`include "max_heap_rekey_sift_down_top_defines.svh"
module mhr_ctrl
	import mhr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire logic     in_opcode,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire mhr_sts_t sts,
	output mhr_cmd_t      cmd
);
	typedef enum logic [7:0] {
		ST_IDLE    = 8'b0000_0001,
		ST_ERR     = 8'b0000_0010,
		ST_RD_SLOT = 8'b0000_0100,
		ST_KIDS    = 8'b0000_1000,
		ST_CMP     = 8'b0001_0000,
		ST_PLACE   = 8'b0010_0000,
		ST_ROOT    = 8'b0100_0000,
		ST_EMIT    = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	move_t  moves_q, moves_d;
	move_t  emit_q, emit_d;
	logic   out_valid_q;
	logic   out_free, in_fire, first_skip;
	move_t  first_idx;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign first_skip = (moves_q == move_t'(MOVE_DEPTH));
	assign first_idx  = first_skip ? move_t'(1) : move_t'(0);

	always_comb begin
		state_d = state_q;
		moves_d = moves_q;
		emit_d  = emit_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_opcode == OP_WRITE) begin
						cmd.wr_in = 1'b1;
					end else begin
						cmd.load_op = 1'b1;
						moves_d     = '0;
						state_d     = sts.slot_err ? ST_ERR : ST_RD_SLOT;
					end
				end
			end
			ST_ERR: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = OUT_ERROR;
					state_d      = ST_IDLE;
				end
			end
			ST_RD_SLOT: begin
				cmd.rd_slot = 1'b1;
				state_d     = ST_KIDS;
			end
			ST_KIDS: begin
				cmd.rd_kids  = 1'b1;
				cmd.load_mov = (moves_q == '0);
				state_d      = ST_CMP;
			end
			ST_CMP: begin
				if (sts.has_move && (moves_q < move_t'(MOVE_DEPTH))) begin
					cmd.step    = 1'b1;
					cmd.buf_idx = moves_q;
					moves_d     = moves_q + move_t'(1);
					state_d     = ST_KIDS;
				end else begin
					state_d = ST_PLACE;
				end
			end
			ST_PLACE: begin
				cmd.place = 1'b1;
				state_d   = ST_ROOT;
			end
			ST_ROOT: begin
				emit_d  = moves_q;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					if (emit_q > first_idx) begin
						cmd.out_kind = OUT_MOVED;
						cmd.buf_idx  = emit_q - move_t'(1);
						emit_d       = emit_q - move_t'(1);
					end else begin
						cmd.out_kind = (moves_q == '0) ? OUT_LAST_STAY : OUT_LAST_MOVED;
						state_d      = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			moves_q     <= '0;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			moves_q <= moves_d;
			emit_q  <= emit_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`MHR_ASSERT_NXT(a_step_advance, state_q == ST_CMP && sts.has_move && moves_q < move_t'(MOVE_DEPTH), state_q == ST_KIDS && moves_q == $past(moves_q) + move_t'(1), "sift step did not advance")
	`MHR_ASSERT_NOW(a_emit_bound, state_q == ST_EMIT, emit_q <= moves_q, "emit index beyond move count")
	`MHR_ASSERT_NXT(a_err_path, in_fire && in_opcode == OP_REKEY && sts.slot_err, state_q == ST_ERR, "out-of-heap rekey missed error path")
endmodule
`default_nettype wire
